### rtl/rmq_pkg.sv
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared constants and types for the rotation matrix to quaternion pipeline.
// ----------------------------------------------------------------------------
package rmq_pkg;

    localparam int DATA_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF  = 14;

    localparam int NORM_BITS = 30;              // the largest normalised magnitude lies in [2^29, 2^30)
    localparam int SQ_BITS   = 2 * NORM_BITS;
    localparam int SUM_BITS  = SQ_BITS + 2;
    localparam int ROOT_BITS = SUM_BITS / 2;

    typedef struct packed {
        logic       degen;
        logic [3:0] neg;
    } rmq_tag_t;

endpackage

### rtl/rmq_front.sv
// ----------------------------------------------------------------------------
// rmq_front
// Branch selection, magnitudes, common normalising shift and sum of squares,
// six register stages.
// ----------------------------------------------------------------------------
module rmq_front
    import rmq_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                in_valid,
    input  logic [8:0][DATA_WIDTH-1:0]          m,
    output logic                                out_valid,
    output logic [3:0][NORM_BITS-1:0]           mag,
    output logic [SUM_BITS-1:0]                 sum,
    output rmq_tag_t                            tag
);

    localparam int CW = ((DATA_WIDTH > FRAC_BITS + 1) ? DATA_WIDTH : FRAC_BITS + 1) + 3;
    localparam int PW = $clog2(CW);
    localparam int LEAD = NORM_BITS - 1;

    logic signed [CW-1:0] a [9];
    logic signed [CW-1:0] trace, r, one_q;
    logic signed [CW-1:0] c [4];

    logic [5:0]           v_reg;

    logic signed [CW-1:0] c1_reg [4];
    logic                 d1_reg;

    logic [3:0][CW-1:0]   m2_reg;
    logic [CW-1:0]        big2_reg;
    rmq_tag_t             t2_reg;

    logic [3:0][CW-1:0]   m3_reg;
    logic [PW-1:0]        p3_reg;
    rmq_tag_t             t3_reg;

    logic [3:0][NORM_BITS-1:0] m4_reg;
    rmq_tag_t                  t4_reg;

    logic [3:0][NORM_BITS-1:0] m5_reg;
    logic [3:0][SQ_BITS-1:0]   sq5_reg;
    rmq_tag_t                  t5_reg;

    logic [3:0][NORM_BITS-1:0] m6_reg;
    logic [SUM_BITS-1:0]       sum6_reg;
    rmq_tag_t                  t6_reg;

    logic [3:0][CW-1:0]   mag_next;
    logic [CW-1:0]        big_next;
    logic [3:0]           neg_next;
    logic [PW-1:0]        p_next;
    logic [3:0][NORM_BITS-1:0] sh_next;

    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            a[i] = CW'($signed(m[i]));
        end
        one_q = CW'(1) <<< FRAC_BITS;
        trace = a[0] + a[4] + a[8];
        if (trace > 0)
        begin
            r    = trace + one_q;
            c[0] = r;
            c[1] = a[5] - a[7];
            c[2] = a[6] - a[2];
            c[3] = a[1] - a[3];
        end
        else if (a[0] > a[4] && a[0] > a[8])
        begin
            r    = one_q + a[0] - a[4] - a[8];
            c[0] = a[5] - a[7];
            c[1] = r;
            c[2] = a[1] + a[3];
            c[3] = a[2] + a[6];
        end
        else if (a[4] > a[8])
        begin
            r    = one_q + a[4] - a[0] - a[8];
            c[0] = a[6] - a[2];
            c[1] = a[1] + a[3];
            c[2] = r;
            c[3] = a[5] + a[7];
        end
        else
        begin
            r    = one_q + a[8] - a[0] - a[4];
            c[0] = a[1] - a[3];
            c[1] = a[2] + a[6];
            c[2] = a[5] + a[7];
            c[3] = r;
        end
    end

    always_comb
    begin
        big_next = '0;
        for (int i = 0; i < 4; i++)
        begin
            neg_next[i] = c1_reg[i][CW-1];
            mag_next[i] = neg_next[i] ? CW'(-c1_reg[i]) : CW'(c1_reg[i]);
            if (mag_next[i] > big_next)
            begin
                big_next = mag_next[i];
            end
        end
    end

    always_comb
    begin
        p_next = '0;
        for (int b = 0; b < CW; b++)
        begin
            if (big2_reg[b])
            begin
                p_next = PW'(b);
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            sh_next[i] = NORM_BITS'({m3_reg[i], {LEAD{1'b0}}} >> p3_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[4:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c1_reg   <= c;
            d1_reg   <= (r <= 0);

            m2_reg   <= mag_next;
            big2_reg <= big_next;
            t2_reg   <= '{degen: d1_reg, neg: neg_next};

            m3_reg   <= m2_reg;
            p3_reg   <= p_next;
            t3_reg   <= t2_reg;

            m4_reg   <= sh_next;
            t4_reg   <= t3_reg;

            m5_reg   <= m4_reg;
            for (int i = 0; i < 4; i++)
            begin
                sq5_reg[i] <= SQ_BITS'(m4_reg[i]) * SQ_BITS'(m4_reg[i]);
            end
            t5_reg   <= t4_reg;

            m6_reg   <= m5_reg;
            sum6_reg <= SUM_BITS'(sq5_reg[0]) + SUM_BITS'(sq5_reg[1])
                      + SUM_BITS'(sq5_reg[2]) + SUM_BITS'(sq5_reg[3]);
            t6_reg   <= t5_reg;
        end
    end

    assign out_valid = v_reg[5];
    assign mag       = m6_reg;
    assign sum       = sum6_reg;
    assign tag       = t6_reg;

endmodule

### rtl/rmq_sqrt.sv
// ----------------------------------------------------------------------------
// rmq_sqrt
// Pipelined integer square root, one result bit per stage, payload alongside.
// ----------------------------------------------------------------------------
module rmq_sqrt
    import rmq_pkg::*;
#(
    parameter int PAY_W = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [SUM_BITS-1:0]   radicand,
    input  logic [PAY_W-1:0]      in_pay,
    output logic                  out_valid,
    output logic [ROOT_BITS-1:0]  root,
    output logic [PAY_W-1:0]      out_pay
);

    localparam int RN = ROOT_BITS;
    localparam int RW = ROOT_BITS + 3;

    logic [RW-1:0]        rem_reg  [RN];
    logic [ROOT_BITS-1:0] root_reg [RN];
    logic [SUM_BITS-1:0]  src_reg  [RN];
    logic [PAY_W-1:0]     pay_reg  [RN];
    logic [RN-1:0]        v_reg;

    for (genvar k = 0; k < RN; k++)
    begin : g_st
        logic [RW-1:0]        ri, rn, tv;
        logic [ROOT_BITS-1:0] qi;
        logic [SUM_BITS-1:0]  si;
        logic [PAY_W-1:0]     pi;
        logic                 vi;

        if (k == 0)
        begin : g_first
            assign ri = '0;
            assign qi = '0;
            assign si = radicand;
            assign pi = in_pay;
            assign vi = in_valid;
        end
        else
        begin : g_next
            assign ri = rem_reg[k-1];
            assign qi = root_reg[k-1];
            assign si = src_reg[k-1];
            assign pi = pay_reg[k-1];
            assign vi = v_reg[k-1];
        end

        assign rn = {ri[RW-3:0], si[SUM_BITS-1 -: 2]};
        assign tv = RW'({qi, 2'b01});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k] <= vi;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (rn >= tv)
                begin
                    rem_reg[k]  <= rn - tv;
                    root_reg[k] <= {qi[ROOT_BITS-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[k]  <= rn;
                    root_reg[k] <= {qi[ROOT_BITS-2:0], 1'b0};
                end
                src_reg[k] <= {si[SUM_BITS-3:0], 2'b00};
                pay_reg[k] <= pi;
            end
        end
    end

    assign out_valid = v_reg[RN-1];
    assign root      = root_reg[RN-1];
    assign out_pay   = pay_reg[RN-1];

endmodule

### rtl/rmq_div.sv
// ----------------------------------------------------------------------------
// rmq_div
// Four-lane pipelined restoring divider, rounded magnitude over the length,
// one quotient bit per stage.
// ----------------------------------------------------------------------------
module rmq_div
    import rmq_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic                            in_valid,
    input  logic [3:0][NORM_BITS-1:0]       mag,
    input  logic [ROOT_BITS-1:0]            len,
    input  rmq_tag_t                        in_tag,
    output logic                            out_valid,
    output logic [3:0][FRAC_BITS+1:0]       quo,
    output rmq_tag_t                        out_tag
);

    localparam int QN = FRAC_BITS + 2;
    localparam int NW = NORM_BITS + 1 + FRAC_BITS;
    localparam int DW = ROOT_BITS + 1;

    logic [3:0][ROOT_BITS-1:0] rem_reg [QN];
    logic [3:0][QN-1:0]        nlo_reg [QN];
    logic [3:0][QN-1:0]        q_reg   [QN];
    logic [ROOT_BITS-1:0]      len_reg [QN];
    rmq_tag_t                  tag_reg [QN];
    logic [QN-1:0]             v_reg;

    for (genvar k = 0; k < QN; k++)
    begin : g_st
        logic [3:0][ROOT_BITS-1:0] ri;
        logic [3:0][QN-1:0]        ni, qi;
        logic [ROOT_BITS-1:0]      li;
        rmq_tag_t                  ti;
        logic                      vi;
        logic [3:0][DW-1:0]        r2;

        if (k == 0)
        begin : g_first
            logic [3:0][NW-1:0] num;
            for (genvar j = 0; j < 4; j++)
            begin : g_lane
                assign num[j] = (NW'(mag[j]) << FRAC_BITS) + NW'(len >> 1);
                assign ri[j]  = ROOT_BITS'(num[j] >> QN);
                assign ni[j]  = num[j][QN-1:0];
            end
            assign qi = '0;
            assign li = len;
            assign ti = in_tag;
            assign vi = in_valid;
        end
        else
        begin : g_next
            assign ri = rem_reg[k-1];
            assign ni = nlo_reg[k-1];
            assign qi = q_reg[k-1];
            assign li = len_reg[k-1];
            assign ti = tag_reg[k-1];
            assign vi = v_reg[k-1];
        end

        for (genvar j = 0; j < 4; j++)
        begin : g_trial
            assign r2[j] = {ri[j], ni[j][QN-1]};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k] <= vi;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int j = 0; j < 4; j++)
                begin
                    if (r2[j] >= DW'(li))
                    begin
                        rem_reg[k][j] <= ROOT_BITS'(r2[j] - DW'(li));
                        q_reg[k][j]   <= {qi[j][QN-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg[k][j] <= ROOT_BITS'(r2[j]);
                        q_reg[k][j]   <= {qi[j][QN-2:0], 1'b0};
                    end
                    nlo_reg[k][j] <= {ni[j][QN-2:0], 1'b0};
                end
                len_reg[k] <= li;
                tag_reg[k] <= ti;
            end
        end
    end

    assign out_valid = v_reg[QN-1];
    assign quo       = q_reg[QN-1];
    assign out_tag   = tag_reg[QN-1];

endmodule

### rtl/rotation_matrix_to_quaternion.sv
// Throughput: one item per cycle when not stalled; six front stages, a 31-stage
// square root and a FRAC_BITS + 2 stage divider, all advancing together with the
// output register. Back-pressure holds the whole pipeline while the output
// item waits.
// Reset: rst_n asynchronous, active low, clears all valid bits; data is not reset.
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Rotation matrix to unit quaternion by Shepperd's method, fixed point.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion
    import rmq_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // m00, m01, m02, m10, m11, m12, m20, m21, m22
    input  logic [((9*DATA_WIDTH+7)/8)*8-1:0]      s_tdata,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // qw, qx, qy, qz
    output logic [((4*DATA_WIDTH+7)/8)*8-1:0]      m_tdata,
    // degenerate
    output logic                                   m_tuser
);

    localparam int OTW = ((4*DATA_WIDTH+7)/8)*8;
    localparam int XW  = 64;
    localparam logic signed [XW-1:0] MAXV = (XW'(1) <<< (DATA_WIDTH-1)) - 1;
    localparam logic signed [XW-1:0] MINV = -MAXV - 1;
    localparam int PAY_W = 4*NORM_BITS + $bits(rmq_tag_t);

    logic                          en;
    logic [8:0][DATA_WIDTH-1:0]    m;

    logic                          f_valid;
    logic [3:0][NORM_BITS-1:0]     f_mag;
    logic [SUM_BITS-1:0]           f_sum;
    rmq_tag_t                      f_tag;

    logic                          s_valid;
    logic [ROOT_BITS-1:0]          s_root;
    logic [PAY_W-1:0]              s_pay;
    logic [3:0][NORM_BITS-1:0]     s_mag;
    rmq_tag_t                      s_tag;

    logic                          d_valid;
    logic [3:0][FRAC_BITS+1:0]     d_quo;
    rmq_tag_t                      d_tag;

    logic [3:0][DATA_WIDTH-1:0]    q_next;
    logic signed [XW-1:0]          xv [4];

    logic                          out_valid_reg;
    logic [3:0][DATA_WIDTH-1:0]    out_q_reg;
    logic                          out_degen_reg;

    assign en       = m_tready || !out_valid_reg;
    assign s_tready = en;

    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            m[i] = s_tdata[i*DATA_WIDTH +: DATA_WIDTH];
        end
    end

    rmq_front #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .m         (m),
        .out_valid (f_valid),
        .mag       (f_mag),
        .sum       (f_sum),
        .tag       (f_tag)
    );

    rmq_sqrt #(.PAY_W(PAY_W)) u_sqrt
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (f_valid),
        .radicand  (f_sum),
        .in_pay    ({f_mag, f_tag}),
        .out_valid (s_valid),
        .root      (s_root),
        .out_pay   (s_pay)
    );

    assign {s_mag, s_tag} = s_pay;

    rmq_div #(.FRAC_BITS(FRAC_BITS)) u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_valid),
        .mag       (s_mag),
        .len       (s_root),
        .in_tag    (s_tag),
        .out_valid (d_valid),
        .quo       (d_quo),
        .out_tag   (d_tag)
    );

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            if (d_tag.degen)
            begin
                xv[i] = (i == 0) ? (XW'(1) <<< FRAC_BITS) : '0;
            end
            else
            begin
                xv[i] = d_tag.neg[i] ? -XW'(d_quo[i]) : XW'(d_quo[i]);
            end
            if (xv[i] > MAXV)
            begin
                q_next[i] = DATA_WIDTH'(MAXV);
            end
            else if (xv[i] < MINV)
            begin
                q_next[i] = DATA_WIDTH'(MINV);
            end
            else
            begin
                q_next[i] = DATA_WIDTH'(xv[i]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= d_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_q_reg     <= q_next;
            out_degen_reg <= d_tag.degen;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OTW'(out_q_reg);
    assign m_tuser  = out_degen_reg;

    a_degen_vec_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> out_q_reg[1] == '0 && out_q_reg[2] == '0
                                && out_q_reg[3] == '0)
        else $error("degenerate item with non-zero vector part");

    a_degen_w_pos: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> !out_q_reg[0][DATA_WIDTH-1] && out_q_reg[0] != '0)
        else $error("degenerate item without positive scalar part");

    a_unit_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> out_q_reg != '0)
        else $error("normalised quaternion is all zero");

    a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(d_quo) && $stable(d_valid))
        else $error("pipeline moved while output stalled");

endmodule
